// ===== sv/gbn_pkg.sv =====
package gbn_pkg;

    localparam int GBN_MAX_WINDOW = 32;
    localparam int GBN_SEQ_BITS   = 16;
    localparam int GBN_FRESH_SPAN = 32767;
    localparam int GBN_LOSS_LIMIT = 3;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_PACKET  = 2'd2;

    localparam logic [2:0] KIND_SYN    = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_ACK    = 3'd2;
    localparam logic [2:0] KIND_FIN    = 3'd3;
    localparam logic [2:0] KIND_CLOSED = 3'd4;

    typedef enum logic [2:0] {
        PH_DISCONNECTED  = 3'd0,
        PH_WAIT_SYN_ACK  = 3'd1,
        PH_WAIT_ACK      = 3'd2,
        PH_WAIT_FIN_ACK  = 3'd3,
        PH_WAIT_PEER_FIN = 3'd4,
        PH_WAIT_CLOSE    = 3'd5,
        PH_CLOSED        = 3'd6
    } gbn_phase_e;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SYN,
        OP_FIN,
        OP_CLOSE,
        OP_PEER_ACK,
        OP_PEER_FIN_WAIT,
        OP_HS_PREP,
        OP_SYNACK_RESET,
        OP_HALVE,
        OP_ADOPT,
        OP_MATCH,
        OP_CUT,
        OP_HS_ACK,
        OP_BURST_STEP
    } gbn_op_e;

    typedef struct packed {
        logic [1:0]  command;
        logic        flag_ack;
        logic        flag_syn;
        logic        flag_fin;
        logic [15:0] peer_seq;
        logic [15:0] ack_number;
        logic [7:0]  peer_window;
        logic [14:0] fresh_seq;
    } gbn_in_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [15:0] send_seq;
        logic [15:0] send_ack;
        logic [7:0]  send_window;
        logic        last;
    } gbn_out_t;

    typedef struct packed {
        gbn_op_e op;
        logic    in_ready;
    } gbn_ctrl_t;

    typedef struct packed {
        gbn_phase_e phase;
        logic [1:0] cmd;
        logic       f_ack;
        logic       f_syn;
        logic       f_fin;
        logic       match;
        logic       fin_due;
        logic       more;
        logic       step_last;
        logic       in_valid;
        logic       out_free;
    } gbn_stat_t;

    function automatic logic gbn_op_emits(input gbn_op_e op);
        logic r;
        case (op)
            OP_SYN, OP_FIN, OP_CLOSE, OP_PEER_ACK, OP_HS_ACK, OP_BURST_STEP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/gbn_chan_if.sv =====
interface gbn_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gbn_ctrl.sv =====
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gbn_stat_t stat,
    output gbn_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SYN,
        S_FIN,
        S_CLOSE,
        S_PEER_ACK,
        S_MATCH,
        S_CUT,
        S_CUT_HS,
        S_HS_ACK,
        S_BURST
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctrl.op       = OP_NONE;
        ctrl.in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    ctrl.op    = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.cmd)
                    CMD_START:
                    begin
                        if (stat.phase == PH_DISCONNECTED || stat.phase == PH_CLOSED)
                            state_next = S_SYN;
                    end
                    CMD_TIMEOUT:
                    begin
                        if (stat.phase == PH_WAIT_SYN_ACK)
                            state_next = S_SYN;
                        else if (stat.phase == PH_WAIT_ACK)
                        begin
                            ctrl.op    = OP_HALVE;
                            state_next = S_CUT;
                        end
                        else if (stat.phase == PH_WAIT_FIN_ACK ||
                                 stat.phase == PH_WAIT_PEER_FIN)
                            state_next = S_FIN;
                        else if (stat.phase == PH_WAIT_CLOSE)
                            state_next = S_CLOSE;
                    end
                    CMD_PACKET:
                    begin
                        if (stat.phase == PH_WAIT_SYN_ACK)
                        begin
                            if (stat.f_ack && stat.f_syn)
                            begin
                                ctrl.op    = OP_HS_PREP;
                                state_next = S_CUT_HS;
                            end
                            else
                                state_next = S_SYN;
                        end
                        else if (stat.phase == PH_WAIT_ACK)
                        begin
                            if (stat.f_ack && stat.f_syn)
                                ctrl.op = OP_SYNACK_RESET;
                            else
                            begin
                                ctrl.op    = OP_ADOPT;
                                state_next = S_MATCH;
                            end
                        end
                        else if (stat.phase == PH_WAIT_FIN_ACK)
                        begin
                            if (stat.f_ack)
                                ctrl.op = OP_PEER_FIN_WAIT;
                        end
                        else if (stat.phase == PH_WAIT_PEER_FIN)
                        begin
                            if (stat.f_fin)
                                state_next = S_PEER_ACK;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SYN:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_SYN;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_CLOSE;
                    state_next = S_IDLE;
                end
            end
            S_PEER_ACK:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_PEER_ACK;
                    state_next = S_IDLE;
                end
            end
            S_MATCH:
            begin
                ctrl.op    = OP_MATCH;
                state_next = (stat.match && stat.fin_due) ? S_FIN : S_CUT;
            end
            S_CUT:
            begin
                ctrl.op    = OP_CUT;
                state_next = S_BURST;
            end
            S_CUT_HS:
            begin
                ctrl.op    = OP_CUT;
                state_next = S_HS_ACK;
            end
            S_HS_ACK:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = OP_HS_ACK;
                    state_next = S_BURST;
                end
            end
            S_BURST:
            begin
                if (!stat.more)
                    state_next = S_IDLE;
                else if (stat.out_free)
                begin
                    ctrl.op = OP_BURST_STEP;
                    if (stat.step_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/gbn_dp.sv =====
module gbn_dp
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = GBN_MAX_WINDOW,
    parameter int SEQ_BITS   = GBN_SEQ_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    gbn_chan_if.sink          events,
    gbn_chan_if.source        results,
    gbn_chan_if.sink          cfg,
    input  gbn_ctrl_t         ctrl,
    output gbn_stat_t         stat
);

    localparam int CW = (SEQ_BITS > 16) ? SEQ_BITS : 16;
    localparam int XW = CW + 1;
    localparam logic [7:0] WMAX = 8'(MAX_WINDOW);
    localparam logic [15:0] ACK_MASK =
        (SEQ_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << SEQ_BITS) - 64'd1);

    gbn_phase_e          phase_reg, phase_next;
    logic [SEQ_BITS-1:0] next_seq_reg, next_seq_next;
    logic [15:0]         done_reg, done_next;
    logic [7:0]          window_reg, window_next;
    logic [1:0]          loss_reg, loss_next;
    logic [15:0]         total_reg, total_next;
    logic                out_valid_reg, out_valid_next;
    gbn_in_t             item_reg, item_next;
    logic [CW-1:0]       cur_reg, cur_next;
    logic [15:0]         end_reg, end_next;
    gbn_out_t            out_reg, out_next;

    logic [XW-1:0] win_edge;
    logic [XW-1:0] ackn_x;
    logic          match;
    logic          adopt;
    logic [7:0]    pwin_cap;
    logic [8:0]    win2;
    logic [7:0]    win_dbl;
    logic [7:0]    win_half;
    logic [14:0]   fresh_mod;
    logic [15:0]   fresh_out;
    logic [15:0]   ack_val;
    logic [7:0]    w_cut;
    logic [15:0]   end_cut;
    logic [CW-1:0] seq_c;
    logic [CW-1:0] done_c;
    logic [CW-1:0] s0;
    logic [CW-1:0] cur_inc;
    logic [1:0]    loss_inc;
    logic          out_free;
    logic          more;
    logic          step_last;

    always_comb
    begin
        win_edge  = XW'(done_reg) + XW'(window_reg);
        ackn_x    = XW'(item_reg.ack_number);
        match     = (win_edge == ackn_x);
        adopt     = (XW'(next_seq_reg) >= win_edge);
        pwin_cap  = (item_reg.peer_window > WMAX) ? WMAX : item_reg.peer_window;
        win2      = {window_reg, 1'b0};
        win_dbl   = (win2 > 9'(MAX_WINDOW)) ? WMAX : win2[7:0];
        win_half  = (window_reg[7:1] == 7'd0) ? 8'd1 : {1'b0, window_reg[7:1]};
        fresh_mod = (item_reg.fresh_seq == 15'(GBN_FRESH_SPAN)) ? 15'd0 : item_reg.fresh_seq;
        fresh_out = 16'(fresh_mod) & ACK_MASK;
        ack_val   = (item_reg.peer_seq + 16'd1) & ACK_MASK;
        if (win_edge > XW'(total_reg))
            w_cut = (total_reg > done_reg) ? 8'(total_reg - done_reg) : 8'd0;
        else
            w_cut = window_reg;
        end_cut   = done_reg + 16'(w_cut);
        seq_c     = CW'(next_seq_reg);
        done_c    = CW'(done_reg);
        s0        = (seq_c < done_c) ? done_c : seq_c;
        cur_inc   = cur_reg + CW'(1);
        loss_inc  = loss_reg + 2'd1;
        out_free  = !out_valid_reg || results.ready;
        more      = (cur_reg < CW'(end_reg));
        step_last = (cur_inc == CW'(end_reg));
    end

    always_comb
    begin
        phase_next     = phase_reg;
        next_seq_next  = next_seq_reg;
        done_next      = done_reg;
        window_next    = window_reg;
        loss_next      = loss_reg;
        total_next     = total_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !results.ready;

        if (cfg.valid)
            total_next = cfg.data;

        case (ctrl.op)
            OP_LATCH:
                item_next = events.data;
            OP_SYN:
            begin
                done_next      = '0;
                window_next    = 8'd1;
                loss_next      = '0;
                next_seq_next  = SEQ_BITS'(fresh_mod);
                phase_next     = PH_WAIT_SYN_ACK;
                out_valid_next = 1'b1;
                out_next       = '{KIND_SYN, fresh_out, 16'd0, 8'd1, 1'b1};
            end
            OP_FIN:
            begin
                next_seq_next  = SEQ_BITS'(fresh_mod);
                phase_next     = PH_WAIT_FIN_ACK;
                out_valid_next = 1'b1;
                out_next       = '{KIND_FIN, fresh_out, 16'd0, window_reg, 1'b1};
            end
            OP_CLOSE:
            begin
                phase_next     = PH_CLOSED;
                out_valid_next = 1'b1;
                out_next       = '{KIND_CLOSED, 16'd0, 16'd0, window_reg, 1'b1};
            end
            OP_PEER_ACK:
            begin
                phase_next     = PH_WAIT_CLOSE;
                out_valid_next = 1'b1;
                out_next       = '{KIND_ACK, item_reg.peer_seq, ack_val, window_reg, 1'b1};
            end
            OP_PEER_FIN_WAIT:
                phase_next = PH_WAIT_PEER_FIN;
            OP_HS_PREP:
                next_seq_next = '0;
            OP_SYNACK_RESET:
            begin
                next_seq_next = '0;
                done_next     = '0;
                window_next   = 8'd1;
                loss_next     = '0;
                phase_next    = PH_WAIT_SYN_ACK;
            end
            OP_HALVE:
            begin
                window_next   = win_half;
                next_seq_next = SEQ_BITS'(done_reg);
            end
            OP_ADOPT:
            begin
                if (adopt)
                    window_next = pwin_cap;
            end
            OP_MATCH:
            begin
                done_next = item_reg.ack_number;
                if (match)
                begin
                    loss_next   = '0;
                    window_next = win_dbl;
                end
                else
                begin
                    next_seq_next = SEQ_BITS'(item_reg.ack_number);
                    if (loss_inc == 2'(GBN_LOSS_LIMIT))
                    begin
                        window_next = 8'd1;
                        loss_next   = '0;
                    end
                    else
                        loss_next = loss_inc;
                end
            end
            OP_CUT:
            begin
                window_next   = w_cut;
                cur_next      = s0;
                end_next      = end_cut;
                next_seq_next = SEQ_BITS'(s0);
                phase_next    = PH_WAIT_ACK;
            end
            OP_HS_ACK:
            begin
                out_valid_next = 1'b1;
                out_next       = '{KIND_ACK, item_reg.peer_seq, ack_val,
                                   item_reg.peer_window, !more};
            end
            OP_BURST_STEP:
            begin
                cur_next       = cur_inc;
                next_seq_next  = SEQ_BITS'(cur_inc);
                out_valid_next = 1'b1;
                out_next       = '{KIND_DATA, cur_reg[15:0], 16'd0, window_reg, step_last};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DISCONNECTED;
            next_seq_reg  <= '0;
            done_reg      <= '0;
            window_reg    <= 8'd1;
            loss_reg      <= '0;
            total_reg     <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            next_seq_reg  <= next_seq_next;
            done_reg      <= done_next;
            window_reg    <= window_next;
            loss_reg      <= loss_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cur_reg  <= cur_next;
        end_reg  <= end_next;
        out_reg  <= out_next;
    end

    assign events.ready  = ctrl.in_ready;
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    assign stat.phase     = phase_reg;
    assign stat.cmd       = item_reg.command;
    assign stat.f_ack     = item_reg.flag_ack;
    assign stat.f_syn     = item_reg.flag_syn;
    assign stat.f_fin     = item_reg.flag_fin;
    assign stat.match     = match;
    assign stat.fin_due   = (item_reg.ack_number >= total_reg);
    assign stat.more      = more;
    assign stat.step_last = step_last;
    assign stat.in_valid  = events.valid;
    assign stat.out_free  = out_free;

endmodule

// ===== sv/go_back_n_sender_unit.sv =====
// Go-back-N sender for one flow.
// events : one word per event (start, timeout, received packet with flags,
//          sequence, cumulative ACK, advertised window and a fresh number).
// results: one word per packet sent (SYN, data, ACK, FIN or closed report);
//          last marks the final word caused by an event.
// cfg    : total_packets write word, taken at any cycle; write it only
//          while the unit is idle.
// An event is taken only while the controller is idle. A single-result event
// (SYN, FIN, ACK, closed) shows its word in the output register, and the unit
// is ready again on the following cycle. A burst after a data ACK passes the
// adopt, match and cut steps before its first word, after a timeout the halve
// and cut steps, then shows one word per cycle while the receiver takes them;
// the handshake ACK comes after the cut step and before its burst. A FIN after
// the final data ACK follows the match step. Events that cause no word, and an
// empty burst, return the controller to idle.
// Reset puts the flow in the disconnected phase with window 1, sequence, done
// and loss counters cleared and total_packets 1. When the receiver stalls, the
// output register holds its word and the controller waits before emitting.
module go_back_n_sender_unit
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = GBN_MAX_WINDOW,
    parameter int SEQ_BITS   = GBN_SEQ_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    gbn_chan_if.sink   events,
    gbn_chan_if.source results,
    gbn_chan_if.sink   cfg
);

    gbn_ctrl_t ctrl;
    gbn_stat_t stat;

    gbn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    gbn_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events),
        .results (results),
        .cfg     (cfg),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.out_free |-> !gbn_op_emits(ctrl.op))
        else $error("emit while output register occupied");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && events.ready) |=> !events.ready)
        else $error("event taken while previous still in work");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.send_kind != KIND_ACK)
        |-> results.data.send_window <= 8'(MAX_WINDOW))
        else $error("window beyond maximum");

    a_data_word: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.send_kind == KIND_DATA)
        |-> (results.data.send_window != 8'd0 && results.data.send_ack == 16'd0))
        else $error("malformed data word");

endmodule
